// ----- rtl/core/mrr_pkg.sv -----
package mrr_pkg;

    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_START  = 16'hFFFF;
    localparam logic [7:0]  ADDR_RESET = 8'h01;
    localparam int          FRAME_LEN  = 6;
    localparam logic [2:0]  LAST_INDEX = 3'd5;
    localparam int          FRAME_W    = FRAME_LEN * 8;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_DATA   = 4'b0010,
        PH_CRC_LO = 4'b0100,
        PH_CRC_HI = 4'b1000
    } t_phase;

    // what the parser hands back for the byte it is consuming
    typedef struct packed {
        logic               at_crc_hi;
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } t_parse_status;

    // one byte through the reflected crc-16, bit at a time
    function automatic logic [15:0] f_crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/mrr_frame_parser.sv -----
module mrr_frame_parser
    import mrr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  logic [7:0]    i_byte,
    input  logic [7:0]    i_own_address,
    output t_parse_status o_status
);

    t_phase             r_phase, n_phase;
    logic [2:0]         r_idx, n_idx;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_crc_lo, n_crc_lo;
    logic [7:0]         r_store [FRAME_LEN];
    logic               store_we;
    logic [2:0]         store_idx;
    logic [15:0]        crc_seed;
    logic [15:0]        crc_folded;
    logic [FRAME_W-1:0] frame_bytes;

    assign crc_seed   = (r_phase == PH_HUNT) ? CRC_START : r_crc;
    assign crc_folded = f_crc_fold(crc_seed, i_byte);

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_crc     = r_crc;
        n_crc_lo  = r_crc_lo;
        store_we  = 1'b0;
        store_idx = r_idx;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_own_address) begin
                    n_idx     = 3'd0;
                    n_crc_lo  = 8'h00;
                    n_crc     = crc_folded;
                    store_we  = 1'b1;
                    store_idx = 3'd0;
                    n_phase   = PH_DATA;
                end
            end
            PH_DATA: begin
                n_idx     = r_idx + 3'd1;
                store_we  = (n_idx < 3'(FRAME_LEN));
                store_idx = n_idx;
                n_crc     = crc_folded;
                if (n_idx >= LAST_INDEX) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                n_crc_lo = i_byte;
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_idx    <= 3'd0;
            r_crc    <= CRC_START;
            r_crc_lo <= 8'h00;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && store_we) begin
            r_store[store_idx] <= i_byte;
        end
    end

    always_comb begin
        for (int j = 0; j < FRAME_LEN; j++) begin
            frame_bytes[j*8 +: 8] = r_store[j];
        end
    end

    assign o_status = '{
        at_crc_hi: (r_phase == PH_CRC_HI),
        hit:       (r_phase == PH_CRC_HI) && (r_crc == {i_byte, r_crc_lo}),
        frame:     frame_bytes
    };

`ifndef SYNTHESIS
    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_idx < LAST_INDEX))
        else $error("frame index ran past the last data byte");

    a_lo_then_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_phase == PH_CRC_LO) |=> (r_phase == PH_CRC_HI))
        else $error("crc high byte phase skipped");

    a_hi_back_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_phase == PH_CRC_HI) |=> (r_phase == PH_HUNT))
        else $error("frame did not end after crc high byte");

    a_data_after_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_phase == PH_HUNT && i_byte == i_own_address)
        |=> (r_phase == PH_DATA && r_idx == 3'd0))
        else $error("address match did not open a frame");
`endif

endmodule

// ----- rtl/core/modbus_rtu_request_receiver.sv -----
// channel    direction  handshake                        payload
// s_axis     in         s_axis_tvalid / s_axis_tready    rx_byte
// m_axis     out        m_axis_tvalid / m_axis_tready    six captured request bytes
// cfg        in         i_cfg_valid / o_cfg_ready        own_address
//
// one byte per cycle unless m_axis stalls; 8-bit crc fold unrolled after input register
// a request enters the output register when its crc high byte leaves the input register
// reset (i_rst_n low, synchronous) clears the hunt state and sets own_address to 1
// a request stalled on m_axis holds the next crc high byte and all input behind it
module modbus_rtu_request_receiver
    import mrr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // [7:0] rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [7:0] station_byte, [15:8] function_byte, [23:16] payload_byte_one,
    // [31:24] payload_byte_two, [39:32] payload_byte_three, [47:40] payload_byte_four
    output logic [FRAME_W-1:0] m_axis_tdata,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    logic [FRAME_W-1:0] r_out_data;
    logic [7:0]         r_own_address;
    logic               advance;
    t_parse_status      status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= ADDR_RESET;
        end else if (i_cfg_valid) begin
            r_own_address <= i_cfg_data;
        end
    end

    // only the crc high byte can need the output register
    assign advance       = r_in_valid && (!status.at_crc_hi || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    mrr_frame_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_byte        (r_in_byte),
        .i_own_address (r_own_address),
        .o_status      (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && status.hit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && status.hit) begin
            r_out_data <= status.frame;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("buffered byte lost while parser stalled");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending request overwritten");

    a_hit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && status.hit) |-> (!r_out_valid || m_axis_tready))
        else $error("request produced with output register full");
`endif

endmodule
